// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the pad serial port.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// The property must never hold at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) !(prop)) \
      else $error("forbidden condition seen");

`endif

// ===== hdl/psp_pkg.sv =====
// Types, codes and constants of the pad serial port.
// No dependencies; used by the core and the top level.
package psp_pkg;

   localparam int ACK_DELAY = 64;
   localparam int ACK_PULSE = 32;

   // Bus access codes carried by the mode field.
   typedef enum logic [2:0] {
      MODE_DATA_WR   = 3'd0,
      MODE_DATA_RD   = 3'd1,
      MODE_CTRL_WR   = 3'd2,
      MODE_STATUS_RD = 3'd3,
      MODE_TICK      = 3'd4
   } mode_type;

   // Configuration register indexes.
   localparam logic [1:0] CSR_BAUD_FACTOR = 2'd0;
   localparam logic [1:0] CSR_BAUD_RELOAD = 2'd1;

   // Baud factor codes; the others give a factor of one.
   localparam logic [1:0] FACTOR_X16 = 2'd2;
   localparam logic [1:0] FACTOR_X64 = 2'd3;

   // Pad bytes and control register bits.
   localparam logic [7:0]  PAD_ADDR      = 8'h01;
   localparam logic [7:0]  PAD_CMD_READ  = 8'h42;
   localparam logic [7:0]  PAD_ID_LO     = 8'h41;
   localparam logic [7:0]  PAD_ID_HI     = 8'h5A;
   localparam logic [7:0]  PAD_NONE      = 8'hFF;
   localparam logic [15:0] CTRL_SEL_MASK = 16'h2003;
   localparam logic [15:0] CTRL_SEL_ON   = 16'h0003;
   localparam logic [15:0] CTRL_WR_MASK  = 16'h3F2F;
   localparam logic [15:0] CTRL_PORT_MASK = 16'h2002;
   localparam int          CTRL_RESET_BIT = 6;
   localparam int          CTRL_IRQ_ACK_BIT = 4;
   localparam int          CTRL_IRQ_EN_BIT = 12;

   // Position in the pad exchange.
   typedef enum logic [4:0] {
      POS_IDLE   = 5'b00001,
      POS_CMD    = 5'b00010,
      POS_ID     = 5'b00100,
      POS_BTN_LO = 5'b01000,
      POS_BTN_HI = 5'b10000
   } pos_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [15:0] wdata;
      logic [15:0] buttons;
   } req_item_type;

   typedef struct packed {
      logic [9:0] rdata;
      logic       irq_raise;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]  factor_sel;
      logic [15:0] reload;
   } cfg_type;

endpackage

// ===== hdl/psp_req_if.sv =====
// Request channel of the pad serial port: valid, ready and one bus access.
// No dependencies.
interface psp_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  mode;
   logic [15:0] wdata;
   logic [15:0] buttons;

   modport source (output valid, output mode, output wdata, output buttons, input ready);
   modport sink (input valid, input mode, input wdata, input buttons, output ready);
endinterface

// ===== hdl/psp_rsp_if.sv =====
// Response channel of the pad serial port: valid, ready and one result.
// No dependencies.
interface psp_rsp_if;
   logic       valid;
   logic       ready;
   logic [9:0] rdata;
   logic       irq_raise;

   modport source (output valid, output rdata, output irq_raise, input ready);
   modport sink (input valid, input rdata, input irq_raise, output ready);
endinterface

// ===== hdl/psp_csr_if.sv =====
// Configuration write channel of the pad serial port.
// No dependencies.
interface psp_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/psp_core.sv =====
// Port state and single-pass update for one bus access or tick.
// Depends on psp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module psp_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  psp_pkg::req_item_type item,
   input  psp_pkg::cfg_type      cfg,
   output psp_pkg::rsp_item_type result
);

   logic [15:0]      control_ff, control_in;
   psp_pkg::pos_type pos_ff, pos_in;
   logic [7:0]       rx_byte_ff, rx_byte_in;
   logic             rx_valid_ff, rx_valid_in;
   logic [24:0]      transfer_wait_ff, transfer_wait_in;
   logic [25:0]      ack_wait_ff, ack_wait_in;
   logic             ack_pending_ff, ack_pending_in;
   logic [5:0]       pulse_wait_ff, pulse_wait_in;
   logic             irq_flag_ff, irq_flag_in;

   // Eight bit times; a bit lasts reload times factor, at least 32 ticks.
   function automatic logic [24:0] shift_time(psp_pkg::cfg_type c);
      logic [15:0] reload;
      logic [21:0] bit_time;
      reload = (c.reload == 16'd0) ? 16'd1 : c.reload;
      unique case (c.factor_sel)
         psp_pkg::FACTOR_X16: bit_time = {2'b00, reload, 4'b0000};
         psp_pkg::FACTOR_X64: bit_time = {reload, 6'b000000};
         default:             bit_time = {6'b000000, reload};
      endcase
      if (bit_time < 22'd32) bit_time = 22'd32;
      return {bit_time, 3'b000};
   endfunction

   always_comb begin
      logic [7:0]  tx;
      logic [7:0]  resp;
      logic        ack;
      logic [15:0] masked;
      logic        do_abort;
      control_in       = control_ff;
      pos_in           = pos_ff;
      rx_byte_in       = rx_byte_ff;
      rx_valid_in      = rx_valid_ff;
      transfer_wait_in = transfer_wait_ff;
      ack_wait_in      = ack_wait_ff;
      ack_pending_in   = ack_pending_ff;
      pulse_wait_in    = pulse_wait_ff;
      irq_flag_in      = irq_flag_ff;
      result           = '0;
      tx               = item.wdata[7:0];
      resp             = psp_pkg::PAD_NONE;
      ack              = 1'b0;
      masked           = item.wdata & psp_pkg::CTRL_WR_MASK;
      do_abort         = 1'b0;

      unique case (psp_pkg::mode_type'(item.mode))
         psp_pkg::MODE_DATA_WR: begin
            if ((control_ff & psp_pkg::CTRL_SEL_MASK) == psp_pkg::CTRL_SEL_ON) begin
               unique case (pos_ff)
                  psp_pkg::POS_CMD: begin
                     resp = psp_pkg::PAD_ID_LO;
                     if (tx == psp_pkg::PAD_CMD_READ) begin
                        ack    = 1'b1;
                        pos_in = psp_pkg::POS_ID;
                     end else begin
                        pos_in = psp_pkg::POS_IDLE;
                     end
                  end
                  psp_pkg::POS_ID: begin
                     resp   = psp_pkg::PAD_ID_HI;
                     ack    = 1'b1;
                     pos_in = psp_pkg::POS_BTN_LO;
                  end
                  psp_pkg::POS_BTN_LO: begin
                     resp   = item.buttons[7:0];
                     ack    = 1'b1;
                     pos_in = psp_pkg::POS_BTN_HI;
                  end
                  psp_pkg::POS_BTN_HI: begin
                     resp   = item.buttons[15:8];
                     pos_in = psp_pkg::POS_IDLE;
                  end
                  default: begin
                     if (tx == psp_pkg::PAD_ADDR) begin
                        ack    = 1'b1;
                        pos_in = psp_pkg::POS_CMD;
                     end
                  end
               endcase
            end
            rx_byte_in       = resp;
            rx_valid_in      = 1'b1;
            transfer_wait_in = shift_time(cfg);
            ack_pending_in   = ack;
            ack_wait_in      = ack ? ({1'b0, transfer_wait_in} + 26'(psp_pkg::ACK_DELAY))
                                   : 26'd0;
         end
         psp_pkg::MODE_DATA_RD: begin
            if (!rx_valid_ff || transfer_wait_ff != 25'd0) begin
               result.rdata = {2'b00, psp_pkg::PAD_NONE};
            end else begin
               result.rdata = {2'b00, rx_byte_ff};
               rx_valid_in  = 1'b0;
            end
         end
         psp_pkg::MODE_CTRL_WR: begin
            control_in = masked;
            if (item.wdata[psp_pkg::CTRL_RESET_BIT]) begin
               control_in  = 16'd0;
               do_abort    = 1'b1;
               irq_flag_in = 1'b0;
            end
            if (item.wdata[psp_pkg::CTRL_IRQ_ACK_BIT]) irq_flag_in = 1'b0;
            // Switching port or select drops whatever exchange was running.
            if ((control_ff & psp_pkg::CTRL_PORT_MASK) !=
                (control_in & psp_pkg::CTRL_PORT_MASK)) do_abort = 1'b1;
            if (do_abort) begin
               pos_in           = psp_pkg::POS_IDLE;
               rx_valid_in      = 1'b0;
               rx_byte_in       = 8'd0;
               transfer_wait_in = 25'd0;
               ack_wait_in      = 26'd0;
               ack_pending_in   = 1'b0;
               pulse_wait_in    = 6'd0;
            end
         end
         psp_pkg::MODE_STATUS_RD: begin
            result.rdata[0] = (transfer_wait_ff == 25'd0);
            result.rdata[1] = rx_valid_ff && (transfer_wait_ff == 25'd0);
            result.rdata[7] = (pulse_wait_ff != 6'd0);
            result.rdata[9] = irq_flag_ff;
         end
         psp_pkg::MODE_TICK: begin
            if (transfer_wait_ff != 25'd0) transfer_wait_in = transfer_wait_ff - 25'd1;
            if (pulse_wait_ff != 6'd0) pulse_wait_in = pulse_wait_ff - 6'd1;
            if (ack_pending_ff) begin
               if (ack_wait_ff != 26'd0) ack_wait_in = ack_wait_ff - 26'd1;
               if (ack_wait_in == 26'd0) begin
                  ack_pending_in = 1'b0;
                  pulse_wait_in  = 6'(psp_pkg::ACK_PULSE);
                  if (control_ff[psp_pkg::CTRL_IRQ_EN_BIT]) begin
                     irq_flag_in      = 1'b1;
                     result.irq_raise = 1'b1;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         control_ff       <= 16'd0;
         pos_ff           <= psp_pkg::POS_IDLE;
         rx_byte_ff       <= 8'd0;
         rx_valid_ff      <= 1'b0;
         transfer_wait_ff <= 25'd0;
         ack_wait_ff      <= 26'd0;
         ack_pending_ff   <= 1'b0;
         pulse_wait_ff    <= 6'd0;
         irq_flag_ff      <= 1'b0;
      end else if (item_valid) begin
         control_ff       <= control_in;
         pos_ff           <= pos_in;
         rx_byte_ff       <= rx_byte_in;
         rx_valid_ff      <= rx_valid_in;
         transfer_wait_ff <= transfer_wait_in;
         ack_wait_ff      <= ack_wait_in;
         ack_pending_ff   <= ack_pending_in;
         pulse_wait_ff    <= pulse_wait_in;
         irq_flag_ff      <= irq_flag_in;
      end
   end

   // A pending acknowledge always has time left to count, and nothing else does.
   `ASSERT_ALWAYS(a_ack_wait_tracks_pending, clock, reset,
                  ack_pending_ff == (ack_wait_ff != 26'd0))
   // The pulse counter is only ever loaded with the pulse length.
   `ASSERT_NEVER(a_pulse_in_range, clock, reset,
                 pulse_wait_ff > 6'(psp_pkg::ACK_PULSE))
   // The exchange is always in exactly one position.
   `ASSERT_ALWAYS(a_pos_onehot, clock, reset, $onehot(pos_ff))

endmodule

// ===== hdl/pad_serial_port_with_ack_timing_unit.sv =====
// Top level of the pad serial port: channels, configuration registers, result register.
// Depends on psp_pkg, the three channel interfaces, psp_core and assert_macros.svh.
//
//   channel    direction  payload                     transfer when
//   req_chan   in         mode, wdata, buttons        valid && ready
//   rsp_chan   out        rdata, irq_raise            valid && ready
//   csr_chan   in         index, data                 valid (ready is always high)
//
// Every request yields one response, registered and valid in the cycle after its transfer.
// A request is taken in every cycle while the result register is empty or being drained.
// The core state updates in the same cycle as the request transfer.
// Reset clears the port state, the baud settings and the response valid flag, not the result data.
// A response held back by the sink stalls all requests until the sink takes it.
`include "assert_macros.svh"

module pad_serial_port_with_ack_timing_unit (
   input logic         clock,
   input logic         reset,
   psp_req_if.sink     req_chan,
   psp_rsp_if.source   rsp_chan,
   psp_csr_if.sink     csr_chan
);

   psp_pkg::cfg_type      cfg_ff, cfg_in;
   psp_pkg::req_item_type req_item;
   psp_pkg::rsp_item_type core_result;
   psp_pkg::rsp_item_type rsp_item_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  req_fire;
   logic                  rsp_fire;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_fire       = rsp_chan.valid && rsp_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign req_item.mode    = req_chan.mode;
   assign req_item.wdata   = req_chan.wdata;
   assign req_item.buttons = req_chan.buttons;

   psp_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (req_fire),
      .item       (req_item),
      .cfg        (cfg_ff),
      .result     (core_result)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            psp_pkg::CSR_BAUD_FACTOR: cfg_in.factor_sel = csr_chan.data[1:0];
            psp_pkg::CSR_BAUD_RELOAD: cfg_in.reload     = csr_chan.data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) rsp_valid_in = 1'b1;
      else if (rsp_fire) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) rsp_item_ff <= core_result;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.rdata     = rsp_item_ff.rdata;
   assign rsp_chan.irq_raise = rsp_item_ff.irq_raise;

   // A request transfer always leaves a response waiting in the next cycle.
   `ASSERT_ALWAYS(a_req_gives_rsp, clock, reset, req_fire |=> rsp_valid_ff)
   // A full result register that is not drained must hold off new requests.
   `ASSERT_NEVER(a_no_overwrite, clock, reset,
                 rsp_valid_ff && !rsp_chan.ready && req_fire)
   // A waiting response keeps its value until the sink takes it.
   `ASSERT_ALWAYS(a_rsp_held, clock, reset,
                  rsp_valid_ff && !rsp_chan.ready |=> rsp_valid_ff && $stable(rsp_item_ff))

endmodule
